/* rtl/core/ntts_pkg.sv */
// Shared types, codes and constants for the nearest-target steering block.
// No dependencies; compile first.
package ntts_pkg;

   localparam int CW         = 36;   // CORDIC x/y datapath width
   localparam int ZW         = 34;   // CORDIC angle accumulator width
   localparam int ATAN_DEPTH = 24;

   localparam logic [30:0] KINV_Q31 = 31'd1304065748;   // 1/K, Q0.31

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_STEER = 2'd2;

   localparam logic [2:0] STAT_CLEARED    = 3'd0;
   localparam logic [2:0] STAT_ADDED      = 3'd1;
   localparam logic [2:0] STAT_FULL       = 3'd2;
   localparam logic [2:0] STAT_STEERED    = 3'd3;
   localparam logic [2:0] STAT_WRONG_KIND = 3'd4;
   localparam logic [2:0] STAT_NO_ENEMY   = 3'd5;
   localparam logic [2:0] STAT_ZERO       = 3'd6;

   localparam logic REG_MAX_TURN    = 1'b0;
   localparam logic REG_HOMING_KIND = 1'b1;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [7:0]  owner;
   } target_type;

   typedef struct packed {
      logic                 start;
      logic                 rotate;   // 1 rotation, 0 vectoring
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_rsp_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2F9;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/ntts_ifs.sv */
// Valid/ready channel interfaces: item input, result output, register write.
// No dependencies.
interface ntts_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic [7:0]         slot;
   logic [7:0]         kind;
   modport source(output valid, operation, pos_x, pos_y, vel_x, vel_y, slot, kind,
                  input ready);
   modport sink(input valid, operation, pos_x, pos_y, vel_x, vel_y, slot, kind,
                output ready);
endinterface

interface ntts_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic [3:0]         chosen_index;
   modport source(output valid, status, new_vel_x, new_vel_y, chosen_index,
                  input ready);
   modport sink(input valid, status, new_vel_x, new_vel_y, chosen_index,
                output ready);
endinterface

interface ntts_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [14:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

/* rtl/core/ntts_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on ntts_pkg.
module ntts_cordic #(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ntts_pkg::cordic_cmd_type cmd,
   output ntts_pkg::cordic_rsp_type rsp
);
   import ntts_pkg::*;

   localparam int NIT = (STEPS > ATAN_DEPTH) ? ATAN_DEPTH : STEPS;
   localparam logic [4:0] LAST = 5'(NIT - 1);
   localparam logic signed [ZW-1:0] QUARTER = 34'sh040000000;
   localparam logic signed [ZW-1:0] HALF    = 34'sh080000000;

   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic [4:0]           it_ff;
   logic                 busy_ff, done_ff, mode_ff;

   always_comb begin
      xs = y_ff >>> it_ff;
      ys = x_ff >>> it_ff;
      at = $signed({2'b00, atan_entry(it_ff)});
      if (mode_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - xs; y_in = y_ff + ys; z_in = z_ff - at;
         end else begin
            x_in = x_ff + xs; y_in = y_ff - ys; z_in = z_ff + at;
         end
      end else begin
         if (!y_ff[CW-1]) begin
            x_in = x_ff + xs; y_in = y_ff - ys; z_in = z_ff + at;
         end else begin
            x_in = x_ff - xs; y_in = y_ff + ys; z_in = z_ff - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            it_ff   <= '0;
            mode_ff <= cmd.rotate;
            if (cmd.rotate) begin
               // pre-rotate by a quarter turn to keep the angle in range
               if (cmd.z > QUARTER) begin
                  x_ff <= -cmd.y; y_ff <= cmd.x; z_ff <= cmd.z - QUARTER;
               end else if (cmd.z < -QUARTER) begin
                  x_ff <= cmd.y; y_ff <= -cmd.x; z_ff <= cmd.z + QUARTER;
               end else begin
                  x_ff <= cmd.x; y_ff <= cmd.y; z_ff <= cmd.z;
               end
            end else if (cmd.x[CW-1]) begin
               x_ff <= -cmd.x; y_ff <= -cmd.y; z_ff <= HALF;
            end else begin
               x_ff <= cmd.x; y_ff <= cmd.y; z_ff <= '0;
            end
         end else if (busy_ff) begin
            x_ff  <= x_in;
            y_ff  <= y_in;
            z_ff  <= z_in;
            it_ff <= it_ff + 5'd1;
            if (it_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;

endmodule

/* rtl/core/nearest_target_turn_limited_steer.sv */
// Top level of the nearest-target, turn-limited steering block.
// Depends on ntts_pkg, ntts_ifs (channel interfaces) and ntts_cordic.
//
// Items arrive on req_ch, one result per item leaves on rsp_ch (operation
// code 3 is dropped with no result), registers are written on csr_ch.
// One item is worked at a time. Clear and add go straight to FIN.
// A steer item walks the target memory one entry at a time (read,
// difference, two squares, compare) for the N listed targets, then makes
// two CORDIC vectoring runs and one rotation run on the shared CORDIC
// unit, then scales the rotated x and y by the CORDIC gain. Early exits
// (wrong kind, no enemy, zero speed or distance, zero turn) return
// sooner. A new item is taken while the previous result still waits in
// the output register.
// Target data sits in a synchronous memory with one write port and one
// read port; writes happen only on add transfers and read data is used
// only during a steer search, so they never overlap and need no forwarding.
module nearest_target_turn_limited_steer #(
   parameter int MAX_TARGETS  = 8,
   parameter int CORDIC_STEPS = 16
) (
   input logic      clock,
   input logic      reset,
   ntts_req_if.sink   req_ch,
   ntts_rsp_if.source rsp_ch,
   ntts_csr_if.sink   csr_ch
);
   import ntts_pkg::*;

   localparam int AW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int CNTW = $clog2(MAX_TARGETS + 1);
   localparam logic [CNTW-1:0] FULL     = CNTW'(MAX_TARGETS);
   localparam logic [3:0]      NONE_IDX = 4'(MAX_TARGETS);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RD    = 5'd1;
   localparam logic [4:0] ST_DIF   = 5'd2;
   localparam logic [4:0] ST_SQA   = 5'd3;
   localparam logic [4:0] ST_SQB   = 5'd4;
   localparam logic [4:0] ST_CMP   = 5'd5;
   localparam logic [4:0] ST_CHK   = 5'd6;
   localparam logic [4:0] ST_VECV  = 5'd7;
   localparam logic [4:0] ST_WAITV = 5'd8;
   localparam logic [4:0] ST_VECD  = 5'd9;
   localparam logic [4:0] ST_WAITD = 5'd10;
   localparam logic [4:0] ST_TURN  = 5'd11;
   localparam logic [4:0] ST_ROT   = 5'd12;
   localparam logic [4:0] ST_WAITR = 5'd13;
   localparam logic [4:0] ST_SABS  = 5'd14;
   localparam logic [4:0] ST_SLO   = 5'd15;
   localparam logic [4:0] ST_SHI   = 5'd16;
   localparam logic [4:0] ST_SOUT  = 5'd17;
   localparam logic [4:0] ST_FIN   = 5'd18;

   logic [4:0]  state_ff;

   // configuration
   logic [14:0] max_turn_ff;
   logic [7:0]  homing_kind_ff;

   // target store
   target_type  mem [MAX_TARGETS];
   target_type  rd_data_ff;
   logic        wr_en;
   logic [CNTW-1:0] count_ff, scan_ff;

   // latched item
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff;
   logic [7:0]         slot_ff;

   // search
   logic signed [32:0] dx, dy;
   logic signed [32:0] dx_ff, dy_ff, bdx_ff, bdy_ff;
   logic [31:0]        mx_ff, my_ff;
   logic [63:0]        sqa_ff, sqb_ff;
   logic [64:0]        sqsum, best_d_ff;
   logic               skip_ff, found_ff;
   logic [AW-1:0]      best_ff;

   // heading and turn
   logic [31:0]        hsum;
   logic [15:0]        cur_ff, want_ff;
   logic signed [15:0] delta;
   logic signed [16:0] d17, mt17, step, step_ff;

   // rotation result and gain scaling
   logic signed [CW-1:0] rx_ff, ry_ff, sel;
   logic [35:0]          mag_ff, p;
   logic                 neg_ff, ycomp_ff;
   logic [48:0]          plo_ff, phi_ff;
   logic [66:0]          prod;
   logic [31:0]          pcap, scaled;

   // result and output register
   logic [2:0]  res_status_ff, out_status_ff;
   logic [31:0] res_vx_ff, res_vy_ff, out_vx_ff, out_vy_ff;
   logic [3:0]  res_idx_ff, out_idx_ff;
   logic        rsp_valid_ff;

   cordic_cmd_type cordic_cmd;
   cordic_rsp_type cordic_rsp;

   logic req_fire, out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign wr_en        = req_fire && (req_ch.operation == OP_ADD) && (count_ff < FULL);

   // target memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= '{px: req_ch.pos_x, py: req_ch.pos_y,
                                    owner: req_ch.slot};
      end
      rd_data_ff <= mem[scan_ff[AW-1:0]];
   end

   ntts_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cordic_cmd),
      .rsp   (cordic_rsp)
   );

   always_comb begin
      cordic_cmd.start  = (state_ff == ST_VECV) || (state_ff == ST_VECD)
                          || (state_ff == ST_ROT);
      cordic_cmd.rotate = (state_ff == ST_ROT);
      cordic_cmd.x      = (state_ff == ST_VECD) ? CW'(bdx_ff) : CW'(vx_ff);
      cordic_cmd.y      = (state_ff == ST_VECD) ? CW'(bdy_ff) : CW'(vy_ff);
      // turn step as a 32-bit binary angle
      cordic_cmd.z      = (state_ff == ST_ROT)
                          ? $signed({{(ZW-33){step_ff[16]}}, step_ff, 16'h0000})
                          : '0;
   end

   always_comb begin
      dx    = $signed({rd_data_ff.px[31], rd_data_ff.px}) - $signed({px_ff[31], px_ff});
      dy    = $signed({rd_data_ff.py[31], rd_data_ff.py}) - $signed({py_ff[31], py_ff});
      sqsum = {1'b0, sqa_ff} + {1'b0, sqb_ff};
      // round 32-bit heading to 16 bits
      hsum = cordic_rsp.z[31:0] + 32'h00008000;
      // shortest signed turn; exact half turn lands negative
      delta = $signed(want_ff - cur_ff);
      d17   = 17'(delta);
      mt17  = $signed({2'b00, max_turn_ff});
      if (d17 > mt17)       step = mt17;
      else if (d17 < -mt17) step = -mt17;
      else                  step = d17;
      sel  = ycomp_ff ? ry_ff : rx_ff;
      prod = {phi_ff, 18'h00000} + {18'h00000, plo_ff} + 67'h40000000;
      p    = prod[66:31];
      if (!neg_ff) begin
         scaled = (p > 36'h07FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
         pcap   = '0;
      end else begin
         pcap   = (p > 36'h080000000) ? 32'h80000000 : p[31:0];
         scaled = ~pcap + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         max_turn_ff    <= 15'd364;
         homing_kind_ff <= 8'd10;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_MAX_TURN:    max_turn_ff    <= csr_ch.wdata;
               REG_HOMING_KIND: homing_kind_ff <= csr_ch.wdata[7:0];
               default: ;
            endcase
         end

         // output register: load from FIN, drop on a result transfer
         if (state_ff == ST_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)              rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  px_ff      <= req_ch.pos_x;
                  py_ff      <= req_ch.pos_y;
                  vx_ff      <= req_ch.vel_x;
                  vy_ff      <= req_ch.vel_y;
                  slot_ff    <= req_ch.slot;
                  res_vx_ff  <= req_ch.vel_x;
                  res_vy_ff  <= req_ch.vel_y;
                  res_idx_ff <= NONE_IDX;
                  scan_ff    <= '0;
                  found_ff   <= 1'b0;
                  case (req_ch.operation)
                     OP_CLEAR: begin
                        count_ff      <= '0;
                        res_status_ff <= STAT_CLEARED;
                        state_ff      <= ST_FIN;
                     end
                     OP_ADD: begin
                        if (count_ff < FULL) begin
                           res_status_ff <= STAT_ADDED;
                           res_idx_ff    <= 4'(count_ff);
                           count_ff      <= count_ff + CNTW'(1);
                        end else begin
                           res_status_ff <= STAT_FULL;
                        end
                        state_ff <= ST_FIN;
                     end
                     OP_STEER: begin
                        if (req_ch.kind != homing_kind_ff) begin
                           res_status_ff <= STAT_WRONG_KIND;
                           state_ff      <= ST_FIN;
                        end else if (count_ff == '0) begin
                           res_status_ff <= STAT_NO_ENEMY;
                           state_ff      <= ST_FIN;
                        end else begin
                           state_ff <= ST_RD;
                        end
                     end
                     default: ;   // unused code: no result
                  endcase
               end
            end
            ST_RD:  state_ff <= ST_DIF;   // memory read in flight
            ST_DIF: begin
               dx_ff    <= dx;
               dy_ff    <= dy;
               mx_ff    <= 32'(dx[32] ? -dx : dx);
               my_ff    <= 32'(dy[32] ? -dy : dy);
               skip_ff  <= (rd_data_ff.owner == slot_ff);
               state_ff <= ST_SQA;
            end
            ST_SQA: begin
               sqa_ff   <= mx_ff * mx_ff;
               state_ff <= ST_SQB;
            end
            ST_SQB: begin
               sqb_ff   <= my_ff * my_ff;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // strict less-than: first listed wins a tie
               if (!skip_ff && (!found_ff || sqsum < best_d_ff)) begin
                  found_ff  <= 1'b1;
                  best_d_ff <= sqsum;
                  best_ff   <= scan_ff[AW-1:0];
                  bdx_ff    <= dx_ff;
                  bdy_ff    <= dy_ff;
               end
               scan_ff <= scan_ff + CNTW'(1);
               if (scan_ff == count_ff - CNTW'(1)) state_ff <= ST_CHK;
               else                               state_ff <= ST_RD;
            end
            ST_CHK: begin
               if (!found_ff) begin
                  res_status_ff <= STAT_NO_ENEMY;
                  state_ff      <= ST_FIN;
               end else begin
                  res_idx_ff <= 4'(best_ff);
                  if ((vx_ff == '0 && vy_ff == '0) || (bdx_ff == '0 && bdy_ff == '0)) begin
                     res_status_ff <= STAT_ZERO;
                     state_ff      <= ST_FIN;
                  end else begin
                     state_ff <= ST_VECV;
                  end
               end
            end
            ST_VECV: state_ff <= ST_WAITV;
            ST_WAITV: begin
               if (cordic_rsp.done) begin
                  cur_ff   <= hsum[31:16];
                  state_ff <= ST_VECD;
               end
            end
            ST_VECD: state_ff <= ST_WAITD;
            ST_WAITD: begin
               if (cordic_rsp.done) begin
                  want_ff  <= hsum[31:16];
                  state_ff <= ST_TURN;
               end
            end
            ST_TURN: begin
               step_ff       <= step;
               res_status_ff <= STAT_STEERED;
               if (step == '0) state_ff <= ST_FIN;
               else            state_ff <= ST_ROT;
            end
            ST_ROT: state_ff <= ST_WAITR;
            ST_WAITR: begin
               if (cordic_rsp.done) begin
                  rx_ff    <= cordic_rsp.x;
                  ry_ff    <= cordic_rsp.y;
                  ycomp_ff <= 1'b0;
                  state_ff <= ST_SABS;
               end
            end
            ST_SABS: begin
               neg_ff   <= sel[CW-1];
               mag_ff   <= 36'(sel[CW-1] ? -sel : sel);
               state_ff <= ST_SLO;
            end
            ST_SLO: begin
               plo_ff   <= mag_ff[17:0] * KINV_Q31;
               state_ff <= ST_SHI;
            end
            ST_SHI: begin
               phi_ff   <= mag_ff[35:18] * KINV_Q31;
               state_ff <= ST_SOUT;
            end
            ST_SOUT: begin
               if (ycomp_ff) begin
                  res_vy_ff <= scaled;
                  state_ff  <= ST_FIN;
               end else begin
                  res_vx_ff <= scaled;
                  ycomp_ff  <= 1'b1;
                  state_ff  <= ST_SABS;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  out_status_ff <= res_status_ff;
                  out_vx_ff     <= res_vx_ff;
                  out_vy_ff     <= res_vy_ff;
                  out_idx_ff    <= res_idx_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.new_vel_x    = out_vx_ff;
   assign rsp_ch.new_vel_y    = out_vy_ff;
   assign rsp_ch.chosen_index = out_idx_ff;

   // list never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("target count past depth");

   // an accepted add into a non-full list bumps the count by one
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (wr_en) |=> (count_ff == $past(count_ff) + CNTW'(1)))
      else $error("add did not advance count");

   // chosen target lies inside the filled part of the list
   a_best_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && found_ff) |-> ({1'b0, best_ff} < {1'b0, count_ff}))
      else $error("chosen target outside list");

   // CORDIC results only show up while a run is awaited
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cordic_rsp.done |-> (state_ff == ST_WAITV || state_ff == ST_WAITD
                           || state_ff == ST_WAITR))
      else $error("unexpected CORDIC completion");

   // no new item while the CORDIC unit is still running
   a_idle_cordic: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !cordic_rsp.busy)
      else $error("item taken with CORDIC busy");

endmodule
